### sv/tsl_pkg.sv
// ----------------------------------------------------------------------------
// tsl_pkg: shared types and constants for the transpose search list
// Request and response payloads, cell control, scan wave and controller states.
// ----------------------------------------------------------------------------
package tsl_pkg;

  localparam int KEY_FIELD_BITS = 32;
  localparam int VALUE_BITS     = 64;
  localparam int POS_BITS       = 4;

  // operation codes carried in the func field
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [KEY_FIELD_BITS-1:0] lookup_key;
    logic [VALUE_BITS-1:0]     record_value;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [POS_BITS-1:0]   position;
    logic [VALUE_BITS-1:0] found_value;
    logic                  dropped;
  } rsp_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift;  // insert: every cell takes its front neighbor's entry
    logic scan;   // search: advance the match wave by one cell
    logic swap;   // search: first matching cell trades places with its front neighbor
  } cell_ctl_t;

  // search result travelling down the chain
  typedef struct packed {
    logic                  found;
    logic                  front;  // match sits in cell zero
    logic [POS_BITS-1:0]   pos;    // cell index, low bits only
    logic [VALUE_BITS-1:0] value;
  } wave_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP,
    ST_DONE
  } state_t;

endpackage

### sv/transpose_search_list.sv
// ----------------------------------------------------------------------------
// transpose_search_list: self-organizing key/record table, transpose rule
// A chain of entry cells with a small controller and a registered response.
// ----------------------------------------------------------------------------
// Usage
//   req channel (req_valid/req_ready/req) carries one operation per
//   transaction: func selects insert at the front or search with transpose.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one response per
//   request, in request order.
// Timing
//   Insert: shifts the whole chain in the accept cycle; the response is
//   registered from ST_DONE, which waits while an older response stalls.
//   Search: the match wave moves one cell per cycle down the chain; a
//   search goes through key latch, the scan along the whole chain, swap
//   and response load.
//   One request is in flight at a time; req_ready is high only when idle.
// Reset
//   rst clears the entry count and the controller; table contents are not
//   cleared, unoccupied cells are never matched.
// Stall
//   A response waiting on rsp_ready holds; the next request can still be
//   accepted and worked on, and its response waits until the slot frees.
// ----------------------------------------------------------------------------
module transpose_search_list #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tsl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tsl_pkg::rsp_t rsp
);

  localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int SCAN_BITS = $clog2(TABLE_DEPTH);

  tsl_pkg::state_t    state, state_next;
  tsl_pkg::cell_ctl_t ctl;

  logic [CNT_BITS-1:0]  count, count_next;
  logic [SCAN_BITS-1:0] scan_cnt, scan_cnt_next;
  logic [KEY_BITS-1:0]  search_key;
  tsl_pkg::rsp_t        pend, pend_next;
  logic                 load_rsp;
  logic                 req_fire;

  logic [KEY_BITS-1:0]            cell_key   [TABLE_DEPTH];
  logic [tsl_pkg::VALUE_BITS-1:0] cell_val   [TABLE_DEPTH];
  logic                           cell_first [TABLE_DEPTH];
  tsl_pkg::wave_t                 cell_wave  [TABLE_DEPTH];
  tsl_pkg::wave_t                 tail;

  assign req_ready = (state == tsl_pkg::ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign tail      = cell_wave[TABLE_DEPTH-1];

  // cell chain
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]            p_key;
    logic [tsl_pkg::VALUE_BITS-1:0] p_val;
    logic [KEY_BITS-1:0]            n_key;
    logic [tsl_pkg::VALUE_BITS-1:0] n_val;
    logic                           n_first;
    tsl_pkg::wave_t                 w_in;
    logic                           occ;

    if (i == 0) begin : g_head
      assign p_key = KEY_BITS'(req.lookup_key);
      assign p_val = req.record_value;
      assign w_in  = '0;
    end else begin : g_body
      assign p_key = cell_key[i-1];
      assign p_val = cell_val[i-1];
      assign w_in  = cell_wave[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign n_key   = '0;
      assign n_val   = '0;
      assign n_first = 1'b0;
    end else begin : g_link
      assign n_key   = cell_key[i+1];
      assign n_val   = cell_val[i+1];
      assign n_first = cell_first[i+1];
    end

    assign occ = (count > CNT_BITS'(i));

    tsl_cell #(
      .IDX      (i),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ),
      .search_key (search_key),
      .prev_key   (p_key),
      .prev_val   (p_val),
      .next_key   (n_key),
      .next_val   (n_val),
      .next_first (n_first),
      .wave_in    (w_in),
      .wave_out   (cell_wave[i]),
      .key        (cell_key[i]),
      .val        (cell_val[i]),
      .first      (cell_first[i])
    );
  end

  // controller: next state, cell commands and pending response
  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_cnt_next = scan_cnt;
    pend_next     = pend;
    ctl           = '0;
    load_rsp      = 1'b0;
    unique case (state)
      tsl_pkg::ST_IDLE: begin
        scan_cnt_next = '0;
        if (req_fire) begin
          if (req.func == tsl_pkg::FUNC_INSERT) begin
            ctl.shift         = 1'b1;
            pend_next         = '0;
            pend_next.dropped = (count == CNT_BITS'(TABLE_DEPTH));
            if (count != CNT_BITS'(TABLE_DEPTH)) begin
              count_next = count + 1'b1;
            end
            state_next = tsl_pkg::ST_DONE;
          end else begin
            state_next = tsl_pkg::ST_SCAN;
          end
        end
      end
      tsl_pkg::ST_SCAN: begin
        ctl.scan      = 1'b1;
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_cnt == SCAN_BITS'(TABLE_DEPTH - 1)) begin
          state_next = tsl_pkg::ST_SWAP;
        end
      end
      tsl_pkg::ST_SWAP: begin
        ctl.swap  = 1'b1;
        pend_next = '0;
        if (tail.found) begin
          pend_next.hit         = 1'b1;
          pend_next.found_value = tail.value;
          pend_next.position    = tail.front ? tail.pos : tail.pos - 1'b1;
        end
        state_next = tsl_pkg::ST_DONE;
      end
      tsl_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          load_rsp   = 1'b1;
          state_next = tsl_pkg::ST_IDLE;
        end
      end
      default: state_next = tsl_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsl_pkg::ST_IDLE;
      count     <= '0;
      scan_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_cnt <= scan_cnt_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (req_fire) begin
      search_key <= KEY_BITS'(req.lookup_key);
    end
    if (load_rsp) begin
      rsp <= pend;
    end
  end

endmodule

### sv/tsl_cell.sv
// ----------------------------------------------------------------------------
// tsl_cell: one table entry of the transpose search list
// Holds a key and record, shifts back on insert, forwards the match wave on
// search and takes part in the transpose swap.
// ----------------------------------------------------------------------------
module tsl_cell #(
  parameter int IDX      = 0,
  parameter int KEY_BITS = 32
) (
  input  logic                           clk,
  input  tsl_pkg::cell_ctl_t             ctl,
  input  logic                           occupied,
  input  logic [KEY_BITS-1:0]            search_key,
  // entry of the cell in front (new item for cell zero)
  input  logic [KEY_BITS-1:0]            prev_key,
  input  logic [tsl_pkg::VALUE_BITS-1:0] prev_val,
  // entry of the cell behind
  input  logic [KEY_BITS-1:0]            next_key,
  input  logic [tsl_pkg::VALUE_BITS-1:0] next_val,
  input  logic                           next_first,
  input  tsl_pkg::wave_t                 wave_in,
  output tsl_pkg::wave_t                 wave_out,
  output logic [KEY_BITS-1:0]            key,
  output logic [tsl_pkg::VALUE_BITS-1:0] val,
  output logic                           first
);

  localparam logic IS_FRONT = (IDX == 0);

  logic           hit_here;
  tsl_pkg::wave_t wave_next;

  // first match along the chain claims the wave
  always_comb begin
    hit_here  = occupied && (key == search_key) && !wave_in.found;
    wave_next = wave_in;
    if (hit_here) begin
      wave_next.found = 1'b1;
      wave_next.front = IS_FRONT;
      wave_next.pos   = tsl_pkg::POS_BITS'(IDX);
      wave_next.value = val;
    end
  end

  // entry storage: shift back, or swap with a neighbor
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key <= prev_key;
      val <= prev_val;
    end else if (ctl.swap && next_first) begin
      key <= next_key;
      val <= next_val;
    end else if (ctl.swap && first && !IS_FRONT) begin
      key <= prev_key;
      val <= prev_val;
    end
  end

  // wave stage and first-match flag
  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      wave_out <= wave_next;
      first    <= hit_here;
    end
  end

endmodule

### sv/tsl_checker.sv
// ----------------------------------------------------------------------------
// tsl_checker: port-level assertions for the transpose search list
// Checks request and response holding, response field consistency and
// single issue.
// ----------------------------------------------------------------------------
module tsl_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input tsl_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input tsl_pkg::rsp_t rsp
);

  // a waiting request transaction holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // misses and inserts report no position or record
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |-> rsp.found_value == '0 && rsp.position == '0)
    else $error("miss or insert response carries data");

  // a search hit never reports a dropped entry
  a_hit_no_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> !rsp.dropped)
    else $error("hit response flagged dropped");

  // one operation in flight: ready falls after every accepted request
  a_single_issue: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

endmodule

bind transpose_search_list tsl_checker u_tsl_checker (.*);
